FILE: rtl/mcc_pkg.sv
`default_nettype none
package mcc_pkg;

    localparam int MAX_IN_COLS  = 256;
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_MAPS     = 8;
    localparam int MAX_KERNEL   = 5;
    localparam int ROW_LIMIT    = 4096;

    localparam logic [1:0] CMD_PIXEL  = 2'd0;
    localparam logic [1:0] CMD_WEIGHT = 2'd1;
    localparam logic [1:0] CMD_BIAS   = 2'd2;

    localparam logic [2:0] REG_IN_ROWS     = 3'd0;
    localparam logic [2:0] REG_IN_COLS     = 3'd1;
    localparam logic [2:0] REG_IN_CHANNELS = 3'd2;
    localparam logic [2:0] REG_OUT_MAPS    = 3'd3;
    localparam logic [2:0] REG_KERNEL_ROWS = 3'd4;
    localparam logic [2:0] REG_KERNEL_COLS = 3'd5;
    localparam logic [2:0] REG_BIAS_ENABLE = 3'd6;

    typedef struct packed {
        logic valid;
        logic first;
        logic chan_first;
        logic last;
    } tap_ctl_t;

    function automatic int unsigned clampu(input int unsigned v, input int unsigned hi);
        int unsigned r;
        r = (v == 0) ? 1 : ((v > hi) ? hi : v);
        return r;
    endfunction

    function automatic int unsigned index_width(input int unsigned n);
        int unsigned r;
        r = (n > 1) ? $clog2(n) : 1;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/mcc_line_store.sv
`default_nettype none
module mcc_line_store #(
    parameter int DEPTH = 5120,
    parameter int AW    = 13
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [15:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [15:0]   rdata
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/mcc_cell.sv
`default_nettype none
module mcc_cell #(
    parameter int WDEPTH = 100,
    parameter int WAW    = 7,
    parameter int NCH    = 4,
    parameter int CW     = 2
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               bias_en,
    input  wire logic               w_we,
    input  wire logic [WAW-1:0]     w_addr,
    input  wire logic [15:0]        w_data,
    input  wire logic               b_we,
    input  wire logic [CW-1:0]      b_sel,
    input  wire logic [31:0]        b_data,
    input  wire mcc_pkg::tap_ctl_t  in_ctl,
    input  wire logic [15:0]        in_pix,
    input  wire logic [WAW-1:0]     in_addr,
    input  wire logic [CW-1:0]      in_fi,
    output mcc_pkg::tap_ctl_t       out_ctl,
    output logic      [15:0]        out_pix,
    output logic      [WAW-1:0]     out_addr,
    output logic      [CW-1:0]      out_fi,
    output logic      [47:0]        acc,
    output logic                    done
);

    logic [15:0]       wmem [WDEPTH];
    logic [15:0]       w_q_reg;
    logic [31:0]       bias_reg [NCH];
    logic [31:0]       bias1_reg;
    mcc_pkg::tap_ctl_t ctl1_reg, ctl2_reg;
    logic [15:0]       pix1_reg;
    logic [WAW-1:0]    addr1_reg;
    logic [CW-1:0]     fi1_reg;
    logic [31:0]       prod_reg;
    logic [31:0]       bterm_reg;
    logic [47:0]       acc_reg, acc_next;
    logic              done_reg;

    always_ff @(posedge aclk) begin
        if (w_we) begin
            wmem[w_addr] <= w_data;
        end
        w_q_reg <= wmem[in_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NCH; i++) begin
                bias_reg[i] <= 32'd0;
            end
        end else if (b_we) begin
            bias_reg[b_sel] <= b_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            done_reg <= ctl2_reg.valid && ctl2_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        pix1_reg  <= in_pix;
        addr1_reg <= in_addr;
        fi1_reg   <= in_fi;
        bias1_reg <= bias_reg[in_fi];
        prod_reg  <= 32'($signed(pix1_reg) * $signed(w_q_reg));
        bterm_reg <= (ctl1_reg.chan_first && bias_en) ? bias1_reg : 32'd0;
        if (ctl2_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    always_comb begin
        acc_next = (ctl2_reg.first ? 48'd0 : acc_reg)
                 + {{16{prod_reg[31]}}, prod_reg}
                 + {{16{bterm_reg[31]}}, bterm_reg};
    end

    assign out_ctl  = ctl1_reg;
    assign out_pix  = pix1_reg;
    assign out_addr = addr1_reg;
    assign out_fi   = fi1_reg;
    assign acc      = acc_reg;
    assign done     = done_reg;

endmodule
`default_nettype wire

FILE: rtl/multichannel_conv2d_forward_unit.sv
// Flow: a pixel that completes no window is only stored in the line store; a window pixel
//   starts a pass over its T = channels*kernel_rows*kernel_cols taps, then drain and emit.
// Input is held off until all out_maps results of a window are sent; the single line store
//   read port feeds one tap per cycle into the chain of per-map MAC cells.
// Reset: synchronous, active low; a clearing pass then zeroes all MAX_CHANNELS*MAX_KERNEL^2
//   words of the weight memories while no word is accepted.
`default_nettype none
module multichannel_conv2d_forward_unit #(
    parameter int MAX_IN_COLS  = mcc_pkg::MAX_IN_COLS,
    parameter int MAX_CHANNELS = mcc_pkg::MAX_CHANNELS,
    parameter int MAX_MAPS     = mcc_pkg::MAX_MAPS,
    parameter int MAX_KERNEL   = mcc_pkg::MAX_KERNEL
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // map_index, channel_index, tap_row, tap_col, data
    input  wire logic [1:0]  s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata,   // map_index_out, out_row, out_col, value
    output logic             m_tlast,
    output logic      [0:0]  m_tuser,   // frame_done
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);

    localparam int LDEPTH = MAX_KERNEL * MAX_CHANNELS * MAX_IN_COLS;
    localparam int LAW    = mcc_pkg::index_width(LDEPTH);
    localparam int WDEPTH = MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int WAW    = mcc_pkg::index_width(WDEPTH);
    localparam int CW     = mcc_pkg::index_width(MAX_CHANNELS);
    localparam int SW     = mcc_pkg::index_width(MAX_KERNEL);
    localparam int COLW   = mcc_pkg::index_width(MAX_IN_COLS);
    localparam int MW     = mcc_pkg::index_width(MAX_MAPS);
    localparam int CNW    = $clog2(MAX_IN_COLS + 1);
    localparam int CCW    = $clog2(MAX_CHANNELS + 1);
    localparam int MCW    = $clog2(MAX_MAPS + 1);
    localparam int KCW    = $clog2(MAX_KERNEL + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]  state_reg;
    logic [12:0] in_rows_reg;
    logic [8:0]  in_cols_reg;
    logic [2:0]  in_ch_reg;
    logic [3:0]  maps_reg;
    logic [2:0]  kr_reg, kc_reg;
    logic        bias_en_reg;

    logic [12:0]     rows_c;
    logic [CNW-1:0]  cols_c;
    logic [CCW-1:0]  chans_c;
    logic [MCW-1:0]  maps_c;
    logic [KCW-1:0]  kr_c, kc_c;

    logic [11:0]     row_reg;
    logic [COLW-1:0] col_reg;
    logic [CW-1:0]   ch_reg;
    logic [SW-1:0]   slot_reg;

    logic [WAW-1:0]  clr_cnt_reg;
    logic [CW-1:0]   fi_reg;
    logic [SW-1:0]   ti_reg, tj_reg, tslot_reg, slot0_reg;
    logic [COLW-1:0] tcol_reg, c0_reg;
    logic [11:0]     r0_reg;
    logic            final_reg;
    logic [MCW-1:0]  emit_cnt_reg;

    mcc_pkg::tap_ctl_t src_ctl_reg;
    logic [WAW-1:0]    src_addr_reg;
    logic [CW-1:0]     src_fi_reg;

    logic [71:0] m_tdata_reg;
    logic        m_tvalid_reg, m_tlast_reg, m_fd_reg;

    logic [1:0]  cmd;
    logic [2:0]  in_map;
    logic [1:0]  in_ch;
    logic [2:0]  in_tr, in_tc;
    logic [31:0] in_data;
    logic        s_fire, pix_fire, win_hit, ch_wrap, col_wrap, row_wrap, tap_last;
    logic [31:0] slot0_tmp;
    logic [LAW-1:0] wr_addr, rd_addr;
    logic [WAW-1:0] issue_waddr;
    mcc_pkg::tap_ctl_t issue_ctl;
    logic [15:0] line_q;

    logic           w_we_any;
    logic [WAW-1:0] w_addr_b;
    logic [15:0]    w_data_b;
    logic [MAX_MAPS-1:0] w_we_v, b_we_v;

    mcc_pkg::tap_ctl_t chain_ctl [MAX_MAPS+1];
    logic [15:0]       chain_pix [MAX_MAPS+1];
    logic [WAW-1:0]    chain_addr [MAX_MAPS+1];
    logic [CW-1:0]     chain_fi [MAX_MAPS+1];
    logic [47:0]       cell_acc [MAX_MAPS];
    logic [MAX_MAPS-1:0] cell_done;

    assign cmd     = s_tuser;
    assign in_map  = s_tdata[2:0];
    assign in_ch   = s_tdata[4:3];
    assign in_tr   = s_tdata[7:5];
    assign in_tc   = s_tdata[10:8];
    assign in_data = s_tdata[42:11];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_tvalid && s_tready;
    assign pix_fire  = s_fire && (cmd == mcc_pkg::CMD_PIXEL);

    always_comb begin
        rows_c  = 13'(mcc_pkg::clampu(32'(in_rows_reg), mcc_pkg::ROW_LIMIT));
        cols_c  = CNW'(mcc_pkg::clampu(32'(in_cols_reg), MAX_IN_COLS));
        chans_c = CCW'(mcc_pkg::clampu(32'(in_ch_reg), MAX_CHANNELS));
        maps_c  = MCW'(mcc_pkg::clampu(32'(maps_reg), MAX_MAPS));
        kr_c    = KCW'(mcc_pkg::clampu(32'(kr_reg), MAX_KERNEL));
        kc_c    = KCW'(mcc_pkg::clampu(32'(kc_reg), MAX_KERNEL));
    end

    always_comb begin
        ch_wrap  = (32'(ch_reg) + 32'd1 >= 32'(chans_c));
        col_wrap = (32'(col_reg) + 32'd1 >= 32'(cols_c));
        row_wrap = (32'(row_reg) + 32'd1 >= 32'(rows_c));
        win_hit  = ch_wrap && (32'(row_reg) + 32'd1 >= 32'(kr_c))
                 && (32'(col_reg) + 32'd1 >= 32'(kc_c))
                 && (32'(row_reg) < 32'(rows_c)) && (32'(col_reg) < 32'(cols_c));
        slot0_tmp = 32'(slot_reg) + MAX_KERNEL + 32'd1 - 32'(kr_c);
        if (slot0_tmp >= MAX_KERNEL) begin
            slot0_tmp = slot0_tmp - MAX_KERNEL;
        end
        wr_addr = LAW'((32'(slot_reg) * MAX_CHANNELS + 32'(ch_reg)) * MAX_IN_COLS
                       + 32'(col_reg));
        rd_addr = LAW'((32'(tslot_reg) * MAX_CHANNELS + 32'(fi_reg)) * MAX_IN_COLS
                       + 32'(tcol_reg));
        issue_waddr = WAW'((32'(fi_reg) * MAX_KERNEL + 32'(ti_reg)) * MAX_KERNEL
                           + 32'(tj_reg));
        tap_last = (32'(fi_reg) + 32'd1 == 32'(chans_c))
                 && (32'(ti_reg) + 32'd1 == 32'(kr_c))
                 && (32'(tj_reg) + 32'd1 == 32'(kc_c));
        issue_ctl.valid      = (state_reg == ST_RUN);
        issue_ctl.first      = (fi_reg == '0) && (ti_reg == '0) && (tj_reg == '0);
        issue_ctl.chan_first = (ti_reg == '0) && (tj_reg == '0);
        issue_ctl.last       = tap_last;
    end

    always_comb begin
        w_we_v   = '0;
        b_we_v   = '0;
        w_we_any = 1'b0;
        w_addr_b = WAW'((32'(in_ch) * MAX_KERNEL + 32'(in_tr)) * MAX_KERNEL + 32'(in_tc));
        w_data_b = in_data[15:0];
        if (state_reg == ST_CLEAR) begin
            w_we_v   = '1;
            w_we_any = 1'b1;
            w_addr_b = clr_cnt_reg;
            w_data_b = 16'd0;
        end else if (s_fire) begin
            for (int k = 0; k < MAX_MAPS; k++) begin
                if ((32'(in_map) == k) && (32'(in_ch) < MAX_CHANNELS)) begin
                    w_we_v[k] = (cmd == mcc_pkg::CMD_WEIGHT)
                              && (32'(in_tr) < MAX_KERNEL) && (32'(in_tc) < MAX_KERNEL);
                    b_we_v[k] = (cmd == mcc_pkg::CMD_BIAS);
                end
            end
            w_we_any = |w_we_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_rows_reg <= 13'd32;
            in_cols_reg <= 9'd32;
            in_ch_reg   <= 3'd1;
            maps_reg    <= 4'd1;
            kr_reg      <= 3'd3;
            kc_reg      <= 3'd3;
            bias_en_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mcc_pkg::REG_IN_ROWS:     in_rows_reg <= cfg_data;
                mcc_pkg::REG_IN_COLS:     in_cols_reg <= cfg_data[8:0];
                mcc_pkg::REG_IN_CHANNELS: in_ch_reg   <= cfg_data[2:0];
                mcc_pkg::REG_OUT_MAPS:    maps_reg    <= cfg_data[3:0];
                mcc_pkg::REG_KERNEL_ROWS: kr_reg      <= cfg_data[2:0];
                mcc_pkg::REG_KERNEL_COLS: kc_reg      <= cfg_data[2:0];
                mcc_pkg::REG_BIAS_ENABLE: bias_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            ch_reg       <= '0;
            slot_reg     <= '0;
            src_ctl_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            emit_cnt_reg <= '0;
        end else begin
            src_ctl_reg <= issue_ctl;
            unique case (state_reg)
                ST_CLEAR: begin
                    if (32'(clr_cnt_reg) + 32'd1 >= WDEPTH) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (pix_fire) begin
                        if (ch_wrap) begin
                            ch_reg <= '0;
                            if (col_wrap) begin
                                col_reg <= '0;
                                if (row_wrap) begin
                                    row_reg  <= '0;
                                    slot_reg <= '0;
                                end else begin
                                    row_reg  <= row_reg + 1'b1;
                                    slot_reg <= (32'(slot_reg) + 32'd1 >= MAX_KERNEL)
                                              ? '0 : slot_reg + 1'b1;
                                end
                            end else begin
                                col_reg <= col_reg + 1'b1;
                            end
                        end else begin
                            ch_reg <= ch_reg + 1'b1;
                        end
                        if (win_hit) begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    if (tap_last) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (cell_done[MAX_MAPS-1]) begin
                        state_reg    <= ST_EMIT;
                        emit_cnt_reg <= '0;
                    end
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        if (emit_cnt_reg < maps_c) begin
                            m_tvalid_reg <= 1'b1;
                            emit_cnt_reg <= emit_cnt_reg + 1'b1;
                        end else begin
                            m_tvalid_reg <= 1'b0;
                            state_reg    <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        src_addr_reg <= issue_waddr;
        src_fi_reg   <= fi_reg;
        if (state_reg == ST_IDLE) begin
            r0_reg    <= 12'(32'(row_reg) + 32'd1 - 32'(kr_c));
            c0_reg    <= COLW'(32'(col_reg) + 32'd1 - 32'(kc_c));
            slot0_reg <= SW'(slot0_tmp);
            tslot_reg <= SW'(slot0_tmp);
            tcol_reg  <= COLW'(32'(col_reg) + 32'd1 - 32'(kc_c));
            final_reg <= row_wrap && col_wrap && (32'(row_reg) + 32'd1 == 32'(rows_c))
                       && (32'(col_reg) + 32'd1 == 32'(cols_c));
            fi_reg    <= '0;
            ti_reg    <= '0;
            tj_reg    <= '0;
        end else if (state_reg == ST_RUN) begin
            if (32'(tj_reg) + 32'd1 >= 32'(kc_c)) begin
                tj_reg   <= '0;
                tcol_reg <= c0_reg;
                if (32'(ti_reg) + 32'd1 >= 32'(kr_c)) begin
                    ti_reg    <= '0;
                    tslot_reg <= slot0_reg;
                    fi_reg    <= fi_reg + 1'b1;
                end else begin
                    ti_reg    <= ti_reg + 1'b1;
                    tslot_reg <= (32'(tslot_reg) + 32'd1 >= MAX_KERNEL)
                               ? '0 : tslot_reg + 1'b1;
                end
            end else begin
                tj_reg   <= tj_reg + 1'b1;
                tcol_reg <= tcol_reg + 1'b1;
            end
        end
        if ((state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready)
            && (emit_cnt_reg < maps_c)) begin
            m_tdata_reg <= {1'b0, cell_acc[emit_cnt_reg[MW-1:0]], 8'(c0_reg), r0_reg,
                            3'(emit_cnt_reg)};
            m_tlast_reg <= (32'(emit_cnt_reg) + 32'd1 == 32'(maps_c));
            m_fd_reg    <= (32'(emit_cnt_reg) + 32'd1 == 32'(maps_c)) && final_reg;
        end
    end

    mcc_line_store #(
        .DEPTH (LDEPTH),
        .AW    (LAW)
    ) u_line (
        .aclk  (aclk),
        .we    (pix_fire),
        .waddr (wr_addr),
        .wdata (in_data[15:0]),
        .raddr (rd_addr),
        .rdata (line_q)
    );

    assign chain_ctl[0]  = src_ctl_reg;
    assign chain_pix[0]  = line_q;
    assign chain_addr[0] = src_addr_reg;
    assign chain_fi[0]   = src_fi_reg;

    for (genvar k = 0; k < MAX_MAPS; k++) begin : g_cell
        mcc_cell #(
            .WDEPTH (WDEPTH),
            .WAW    (WAW),
            .NCH    (MAX_CHANNELS),
            .CW     (CW)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .bias_en  (bias_en_reg),
            .w_we     (w_we_v[k] && w_we_any),
            .w_addr   (w_addr_b),
            .w_data   (w_data_b),
            .b_we     (b_we_v[k]),
            .b_sel    (CW'(in_ch)),
            .b_data   (in_data),
            .in_ctl   (chain_ctl[k]),
            .in_pix   (chain_pix[k]),
            .in_addr  (chain_addr[k]),
            .in_fi    (chain_fi[k]),
            .out_ctl  (chain_ctl[k+1]),
            .out_pix  (chain_pix[k+1]),
            .out_addr (chain_addr[k+1]),
            .out_fi   (chain_fi[k+1]),
            .acc      (cell_acc[k]),
            .done     (cell_done[k])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_fd_reg;

    a_no_input_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken while a result waits");

    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready) else $error("input taken during clear");

    a_done_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_done[MAX_MAPS-1] |-> (state_reg == ST_DRAIN))
        else $error("chain finished outside drain");

    a_run_no_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |=> !$rose(m_tvalid)) else $error("result during taps");

endmodule
`default_nettype wire

FILE: tb/tb_multichannel_conv2d_forward_unit.sv
`default_nettype none
module tb_multichannel_conv2d_forward_unit;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0]  map_idx;
        logic [11:0] row;
        logic [7:0]  col;
        logic [47:0] value;
        logic        last;
        logic        frame_done;
    } conv_result_t;

    class conv_scoreboard;
        logic [15:0] pixels [mcc_pkg::MAX_KERNEL][mcc_pkg::MAX_CHANNELS][mcc_pkg::MAX_IN_COLS];
        logic [15:0] weights [mcc_pkg::MAX_MAPS][mcc_pkg::MAX_CHANNELS]
                             [mcc_pkg::MAX_KERNEL][mcc_pkg::MAX_KERNEL];
        logic [31:0] biases [mcc_pkg::MAX_MAPS][mcc_pkg::MAX_CHANNELS];
        int unsigned regs [7];
        int unsigned chan_cnt, col_cnt, row_cnt;
        conv_result_t expected_q[$];
        int mismatches;

        function void clear();
            foreach (pixels[a, b, c]) pixels[a][b][c] = '0;
            foreach (weights[a, b, c, d]) weights[a][b][c][d] = '0;
            foreach (biases[a, b]) biases[a][b] = '0;
            regs = '{32, 32, 1, 1, 3, 3, 0};
            chan_cnt = 0; col_cnt = 0; row_cnt = 0;
            mismatches = 0;
        endfunction

        function int unsigned lim(int unsigned v, int unsigned hi);
            return v == 0 ? 1 : (v > hi ? hi : v);
        endfunction

        function void note_config(logic [2:0] idx, logic [12:0] d);
            case (idx)
                mcc_pkg::REG_IN_ROWS:     regs[0] = 32'(d);
                mcc_pkg::REG_IN_COLS:     regs[1] = 32'(d[8:0]);
                mcc_pkg::REG_IN_CHANNELS: regs[2] = 32'(d[2:0]);
                mcc_pkg::REG_OUT_MAPS:    regs[3] = 32'(d[3:0]);
                mcc_pkg::REG_KERNEL_ROWS: regs[4] = 32'(d[2:0]);
                mcc_pkg::REG_KERNEL_COLS: regs[5] = 32'(d[2:0]);
                mcc_pkg::REG_BIAS_ENABLE: regs[6] = 32'(d[0]);
                default: ;
            endcase
        endfunction

        function void note_input(logic [1:0] cmd, logic [47:0] td);
            int unsigned m, c, tr, tc, rows, cols, chans, maps, kr, kc, r, cl, ch, r0, c0;
            logic signed [63:0] acc;
            conv_result_t res;
            m = 32'(td[2:0]); c = 32'(td[4:3]); tr = 32'(td[7:5]); tc = 32'(td[10:8]);
            if (cmd == mcc_pkg::CMD_WEIGHT) begin
                if (tr < mcc_pkg::MAX_KERNEL && tc < mcc_pkg::MAX_KERNEL)
                    weights[m][c][tr][tc] = td[26:11];
                return;
            end
            if (cmd == mcc_pkg::CMD_BIAS) begin
                biases[m][c] = td[42:11];
                return;
            end
            if (cmd != mcc_pkg::CMD_PIXEL) return;
            rows = lim(regs[0], mcc_pkg::ROW_LIMIT); cols = lim(regs[1], mcc_pkg::MAX_IN_COLS);
            chans = lim(regs[2], mcc_pkg::MAX_CHANNELS); maps = lim(regs[3], mcc_pkg::MAX_MAPS);
            kr = lim(regs[4], mcc_pkg::MAX_KERNEL); kc = lim(regs[5], mcc_pkg::MAX_KERNEL);
            r = row_cnt % mcc_pkg::ROW_LIMIT;
            cl = col_cnt % mcc_pkg::MAX_IN_COLS;
            ch = chan_cnt % mcc_pkg::MAX_CHANNELS;
            pixels[r % mcc_pkg::MAX_KERNEL][ch][cl] = td[26:11];
            if (ch + 1 >= chans && r + 1 >= kr && cl + 1 >= kc && r < rows && cl < cols) begin
                r0 = r + 1 - kr; c0 = cl + 1 - kc;
                for (int mo = 0; mo < maps; mo++) begin
                    acc = 0;
                    for (int f = 0; f < chans; f++) begin
                        for (int i = 0; i < kr; i++)
                            for (int j = 0; j < kc; j++)
                                acc += $signed(pixels[(r0 + i) % mcc_pkg::MAX_KERNEL][f][c0 + j])
                                     * $signed(weights[mo][f][i][j]);
                        if (regs[6] != 0) acc += $signed(biases[mo][f]);
                    end
                    res.map_idx = 3'(mo); res.row = 12'(r0); res.col = 8'(c0);
                    res.value = acc[47:0];
                    res.last = (mo + 1 == maps);
                    res.frame_done = res.last && r + 1 == rows && cl + 1 == cols;
                    expected_q = {expected_q, res};
                end
            end
            if (ch + 1 >= chans) begin
                chan_cnt = 0;
                if (cl + 1 >= cols) begin
                    col_cnt = 0;
                    row_cnt = (r + 1 >= rows) ? 0 : r + 1;
                end else col_cnt = cl + 1;
            end else chan_cnt = ch + 1;
        endfunction

        function void check_result(conv_result_t got);
            conv_result_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected map %0d row %0d col %0d val %h l %b f %b,",
                              " got map %0d row %0d col %0d val %h l %b f %b"},
                        want.map_idx, want.row, want.col, want.value, want.last, want.frame_done,
                        got.map_idx, got.row, got.col, got.value, got.last, got.frame_done);
            end
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid, m_tready = 0, m_tlast;
    logic [71:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_valid = 0, cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [12:0] cfg_data = '0;

    conv_scoreboard sb;
    int send_idle_pct, recv_stall_pct;

    multichannel_conv2d_forward_unit u_top (.*);

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result({m_tdata[2:0], m_tdata[14:3], m_tdata[22:15], m_tdata[70:23],
                                 m_tlast, m_tuser[0]});
            if (cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_word(logic [1:0] cmd, logic [2:0] m, logic [1:0] c,
                             logic [2:0] tr, logic [2:0] tc, logic [31:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {5'd0, d, tc, tr, c, m};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [12:0] d);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic setup(int rows, int cols, int ch, int maps, int kr, int kc, int be);
        drain();
        write_reg(mcc_pkg::REG_IN_ROWS, 13'(rows));
        write_reg(mcc_pkg::REG_IN_COLS, 13'(cols));
        write_reg(mcc_pkg::REG_IN_CHANNELS, 13'(ch));
        write_reg(mcc_pkg::REG_OUT_MAPS, 13'(maps));
        write_reg(mcc_pkg::REG_KERNEL_ROWS, 13'(kr));
        write_reg(mcc_pkg::REG_KERNEL_COLS, 13'(kc));
        write_reg(mcc_pkg::REG_BIAS_ENABLE, 13'(be));
        cfg_valid <= 0;
    endtask

    function automatic logic [31:0] rand_data();
        case ($urandom_range(3))
            0: return 32'h8000_0000 | $urandom_range(15);
            1: return 32'h7FFF_FFFF - $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    task automatic load_all(int maps, int ch, int kr, int kc);
        for (int m = 0; m < maps; m++)
            for (int c = 0; c < ch; c++) begin
                send_word(mcc_pkg::CMD_BIAS, 3'(m), 2'(c), 3'($urandom), 3'($urandom),
                          rand_data());
                for (int i = 0; i < kr; i++)
                    for (int j = 0; j < kc; j++)
                        send_word(mcc_pkg::CMD_WEIGHT, 3'(m), 2'(c), 3'(i), 3'(j),
                                  rand_data());
            end
    endtask

    task automatic frame(int rows, int cols, int ch);
        for (int n = 0; n < rows * cols * ch; n++) begin
            if ($urandom_range(19) == 0)
                send_word(CMD_UNUSED, 3'($urandom), 2'($urandom), 3'($urandom),
                          3'($urandom), $urandom);
            send_word(mcc_pkg::CMD_PIXEL, 3'($urandom), 2'($urandom), 3'($urandom),
                      3'($urandom), rand_data());
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: out-of-range loads, extremes, odd commands
        send_word(mcc_pkg::CMD_WEIGHT, 7, 3, 7, 7, 32'hFFFF_FFFF);
        send_word(mcc_pkg::CMD_WEIGHT, 7, 3, 4, 5, 32'h1234);
        send_word(mcc_pkg::CMD_WEIGHT, 0, 0, 0, 0, 32'h0000_8000);
        send_word(mcc_pkg::CMD_WEIGHT, 0, 0, 1, 1, 32'h0000_7FFF);
        send_word(mcc_pkg::CMD_BIAS, 0, 0, 7, 7, 32'h8000_0000);
        send_word(CMD_UNUSED, 7, 3, 7, 7, 32'hFFFF_FFFF);
        setup(3, 4, 1, 1, 2, 2, 1);
        for (int n = 0; n < 12; n++)
            send_word(mcc_pkg::CMD_PIXEL, 0, 0, 0, 0, n[0] ? 32'hFFFF_8000 : 32'h0000_7FFF);
        setup(2, 2, 1, 1, 3, 3, 0);   // kernel larger than image
        frame(2, 2, 1);
        setup(8191, 511, 7, 15, 7, 7, 1);  // clamped to maxima, then restore
        setup(0, 0, 0, 0, 0, 0, 0);        // zero acts as one
        load_all(1, 1, 1, 1);
        frame(2, 3, 1);
        for (int ph = 0; ph < 6; ph++) begin
            int rows, cols, ch, maps, kr, kc;
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            kr = $urandom_range(1, 3); kc = $urandom_range(1, 3);
            ch = $urandom_range(1, 2);
            maps = $urandom_range(1, 2);
            rows = kr + $urandom_range(0, 1);
            cols = kc + $urandom_range(0, 1);
            if (ph == 4) begin kr = 5; kc = 5; ch = 1; maps = 1; rows = 5; cols = 6; end
            if (ph == 5) begin kr = 1; kc = 1; ch = 4; maps = 8; rows = 2; cols = 2; end
            setup(rows, cols, ch, maps, kr, kc, $urandom_range(1));
            load_all(maps, ch, kr, kc);
            frame(rows, cols, ch);
        end
        drain();
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/mcc_pkg.sv
rtl/mcc_line_store.sv
rtl/mcc_cell.sv
rtl/multichannel_conv2d_forward_unit.sv
tb/tb_multichannel_conv2d_forward_unit.sv
